### src/bdq_pkg.sv
package bdq_pkg;

  localparam int unsigned ListDepth = 16;
  localparam int unsigned IdxW = (ListDepth > 1) ? $clog2(ListDepth) : 1;
  localparam int unsigned CntW = $clog2(ListDepth + 1);
  localparam int unsigned ResultLimit = 16;
  localparam int unsigned PosW = 4;
  localparam int unsigned RlimW = $clog2(ResultLimit + 1);

  typedef enum logic [2:0] {
    CMD_APPEND   = 3'd0,
    CMD_POP_HEAD = 3'd1,
    CMD_POP_TAIL = 3'd2,
    CMD_SEARCH   = 3'd3,
    CMD_PRODUCT  = 3'd4,
    CMD_DUMP     = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_ZERO_DIV = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] item_value;
    logic signed [31:0] search_key;
    logic signed [31:0] divisor;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         position;
    logic signed [31:0] result_value;
    logic               last;
  } out_beat_t;

  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_RD,
    FSM_WAIT,
    FSM_EVAL,
    FSM_DIV,
    FSM_MUL,
    FSM_EMIT,
    FSM_FINAL
  } fsm_e;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic zero_rem;
  } div_rsp_t;

endpackage

### src/bdq_divider.sv
module bdq_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bdq_pkg::div_req_t req_i,
  output bdq_pkg::div_rsp_t rsp_o
);

  logic [31:0] num_q, num_d;
  logic [31:0] den_q, den_d;
  logic [32:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] shifted;

  // restoring division of magnitudes, one quotient bit per cycle
  always_comb begin
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q[31:0], num_q[31]};
    if (req_i.start) begin
      num_d  = req_i.dividend;
      den_d  = req_i.divisor;
      rem_d  = '0;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[30:0], 1'b0};
      if (shifted >= {1'b0, den_q}) begin
        rem_d = shifted - {1'b0, den_q};
      end else begin
        rem_d = shifted;
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.zero_rem = (rem_q == '0);

`ifndef ASSERT_OFF
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without busy");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !req_i.start) else $error("restart while busy");
  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("done while busy");
`endif

endmodule

### src/bounded_deque_search_engine.sv
// Bounded deque of signed 32-bit words with search, product and dump.
// Input channel: in_valid_i / in_stall_o carry one command beat (in_beat_i).
// Output channel: out_valid_o / out_stall_i carry result beats (out_beat_o);
// last marks the final result of a command.
// Elements sit in a 16-entry ring memory with a registered read port.
// One command is handled at a time; in_stall_o is high while busy.
// Append / removals pass RD, WAIT and FINAL; the result is registered in FINAL
// and the next command is taken once the engine is back in IDLE.
// Search and dump walk each entry through RD, WAIT, EVAL and EMIT; each hit is sent one
// hit late so that last can be set on the final one.
// Product: each entry passes RD, WAIT and DIV (the remainder unit), then MUL, a
// multiply step, when the divisor divides it.
// The remainder unit, one bit per cycle, sets the product rate.
// A stalled result holds in the output register; the walk waits for it.
// Reset clears the front pointer, the count and the handshake state;
// the memory is not cleared, only written slots are ever read.
module bounded_deque_search_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bdq_pkg::in_beat_t   in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bdq_pkg::out_beat_t  out_beat_o
);

  localparam int unsigned IW = bdq_pkg::IdxW;
  localparam int unsigned CW = bdq_pkg::CntW;

  bdq_pkg::fsm_e     state_q, state_d;
  bdq_pkg::in_beat_t cmd_q, cmd_d;
  logic [IW-1:0]     front_q, front_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [bdq_pkg::RlimW-1:0] nres_q, nres_d;
  logic [31:0]       prod_q, prod_d;
  logic [31:0]       elem_q, elem_d;
  logic              ovalid_q, ovalid_d;
  bdq_pkg::out_beat_t obeat_q, obeat_d;

  logic [31:0]       mem [bdq_pkg::ListDepth];
  logic [31:0]       rdata_q;
  logic              we;
  logic [IW-1:0]     waddr, raddr;
  logic [31:0]       wdata;

  bdq_pkg::div_req_t div_req;
  bdq_pkg::div_rsp_t div_rsp;

  bdq_divider u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  function automatic logic [IW-1:0] slot(input logic [IW-1:0] f,
                                         input logic [CW-1:0] i);
    logic [CW:0] s;
    s = {1'b0, {(CW-IW){1'b0}}, f} + {1'b0, i};
    if (s >= (CW+1)'(bdq_pkg::ListDepth)) begin
      s = s - (CW+1)'(bdq_pkg::ListDepth);
    end
    return s[IW-1:0];
  endfunction

  function automatic logic [31:0] mag(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  logic out_free;
  assign out_free = !ovalid_q || !out_stall_i;

  assign in_stall_o = (state_q != bdq_pkg::FSM_IDLE);

  logic [31:0] mul_full;
  assign mul_full = prod_q * elem_q;

  // next state
  always_comb begin
    bdq_pkg::cmd_e c;
    state_d = state_q;
    c = bdq_pkg::cmd_e'(cmd_q.cmd);
    case (state_q)
      bdq_pkg::FSM_IDLE: begin
        if (in_valid_i) begin
          case (bdq_pkg::cmd_e'(in_beat_i.cmd))
            bdq_pkg::CMD_APPEND, bdq_pkg::CMD_POP_HEAD, bdq_pkg::CMD_POP_TAIL:
              state_d = bdq_pkg::FSM_RD;
            bdq_pkg::CMD_SEARCH, bdq_pkg::CMD_PRODUCT, bdq_pkg::CMD_DUMP:
              state_d = bdq_pkg::FSM_RD;
            default: state_d = bdq_pkg::FSM_IDLE;
          endcase
        end
      end
      bdq_pkg::FSM_RD: begin
        case (c)
          bdq_pkg::CMD_APPEND, bdq_pkg::CMD_POP_HEAD, bdq_pkg::CMD_POP_TAIL:
            state_d = bdq_pkg::FSM_WAIT;
          bdq_pkg::CMD_PRODUCT:
            if (cmd_q.divisor == '0 || idx_q >= count_q) state_d = bdq_pkg::FSM_FINAL;
            else state_d = bdq_pkg::FSM_WAIT;
          default:
            if (idx_q >= count_q || nres_q == bdq_pkg::RlimW'(bdq_pkg::ResultLimit))
              state_d = bdq_pkg::FSM_FINAL;
            else state_d = bdq_pkg::FSM_WAIT;
        endcase
      end
      bdq_pkg::FSM_WAIT: begin
        case (c)
          bdq_pkg::CMD_APPEND, bdq_pkg::CMD_POP_HEAD, bdq_pkg::CMD_POP_TAIL:
            state_d = bdq_pkg::FSM_FINAL;
          bdq_pkg::CMD_PRODUCT: state_d = bdq_pkg::FSM_DIV;
          default: state_d = bdq_pkg::FSM_EVAL;
        endcase
      end
      bdq_pkg::FSM_EVAL: state_d = bdq_pkg::FSM_EMIT;
      bdq_pkg::FSM_DIV: begin
        if (div_rsp.done) state_d = div_rsp.zero_rem ? bdq_pkg::FSM_MUL : bdq_pkg::FSM_RD;
      end
      bdq_pkg::FSM_MUL: state_d = bdq_pkg::FSM_RD;
      bdq_pkg::FSM_EMIT: if (out_free) state_d = bdq_pkg::FSM_RD;
      bdq_pkg::FSM_FINAL: if (out_free) state_d = bdq_pkg::FSM_IDLE;
      default: state_d = bdq_pkg::FSM_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    bdq_pkg::cmd_e c;
    logic          match;
    logic          more;
    logic [CW-1:0] nxt;
    cmd_d    = cmd_q;
    front_d  = front_q;
    count_d  = count_q;
    idx_d    = idx_q;
    nres_d   = nres_q;
    prod_d   = prod_q;
    elem_d   = elem_q;
    ovalid_d = ovalid_q && out_stall_i;
    obeat_d  = obeat_q;
    we       = 1'b0;
    waddr    = slot(front_q, count_q);
    wdata    = cmd_q.item_value;
    raddr    = slot(front_q, idx_q);
    div_req  = '{start: 1'b0, dividend: mag(rdata_q), divisor: mag(cmd_q.divisor)};
    c        = bdq_pkg::cmd_e'(cmd_q.cmd);
    match    = 1'b0;
    nxt      = idx_q + CW'(1);
    more     = 1'b0;
    case (state_q)
      bdq_pkg::FSM_IDLE: begin
        if (in_valid_i) begin
          cmd_d  = in_beat_i;
          idx_d  = '0;
          nres_d = '0;
          prod_d = 32'd1;
          if (bdq_pkg::cmd_e'(in_beat_i.cmd) == bdq_pkg::CMD_POP_TAIL) begin
            idx_d = count_q - CW'(1);
          end
        end
      end
      bdq_pkg::FSM_WAIT: begin
        if (c == bdq_pkg::CMD_PRODUCT) div_req.start = 1'b1;
      end
      bdq_pkg::FSM_EVAL: elem_d = rdata_q;
      bdq_pkg::FSM_DIV: begin
        elem_d = rdata_q;
        if (div_rsp.done) idx_d = nxt;
      end
      bdq_pkg::FSM_MUL: prod_d = mul_full;
      bdq_pkg::FSM_EMIT: begin
        match = (c == bdq_pkg::CMD_DUMP) || (elem_q == cmd_q.search_key);
        if (out_free) begin
          if (match) begin
            more = (nxt < count_q) &&
                   (nres_q + 1'b1 != bdq_pkg::RlimW'(bdq_pkg::ResultLimit));
            if (c == bdq_pkg::CMD_DUMP && nxt < count_q &&
                nres_q + 1'b1 == bdq_pkg::RlimW'(bdq_pkg::ResultLimit)) more = 1'b0;
            ovalid_d = 1'b1;
            obeat_d.status       = bdq_pkg::ST_OK;
            obeat_d.position     = idx_q[bdq_pkg::PosW-1:0];
            obeat_d.result_value = (c == bdq_pkg::CMD_DUMP) ? elem_q : cmd_q.search_key;
            obeat_d.last         = 1'b0;
            nres_d = nres_q + 1'b1;
          end
          idx_d = nxt;
          cmd_d.item_value = {31'd0, match};
        end
      end
      bdq_pkg::FSM_FINAL: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          obeat_d.position     = '0;
          obeat_d.result_value = '0;
          obeat_d.last         = 1'b1;
          case (c)
            bdq_pkg::CMD_APPEND: begin
              if (count_q >= CW'(bdq_pkg::ListDepth)) begin
                obeat_d.status = bdq_pkg::ST_FULL;
              end else begin
                we = 1'b1;
                obeat_d.status       = bdq_pkg::ST_OK;
                obeat_d.position     = count_q[bdq_pkg::PosW-1:0];
                obeat_d.result_value = cmd_q.item_value;
                count_d = count_q + CW'(1);
              end
            end
            bdq_pkg::CMD_POP_HEAD, bdq_pkg::CMD_POP_TAIL: begin
              if (count_q == '0) begin
                obeat_d.status = bdq_pkg::ST_EMPTY;
              end else begin
                obeat_d.status       = bdq_pkg::ST_OK;
                obeat_d.result_value = rdata_q;
                count_d = count_q - CW'(1);
                if (c == bdq_pkg::CMD_POP_HEAD) front_d = slot(front_q, CW'(1));
                else obeat_d.position = idx_q[bdq_pkg::PosW-1:0];
              end
            end
            bdq_pkg::CMD_PRODUCT: begin
              if (cmd_q.divisor == '0) obeat_d.status = bdq_pkg::ST_ZERO_DIV;
              else begin
                obeat_d.status       = bdq_pkg::ST_OK;
                obeat_d.result_value = prod_q;
              end
            end
            default: begin
              // search / dump: close the stream or report nothing seen
              if (nres_q != '0) begin
                ovalid_d = 1'b0;
              end else begin
                obeat_d.status = (c == bdq_pkg::CMD_DUMP) ? bdq_pkg::ST_EMPTY
                                                          : bdq_pkg::ST_NOTFOUND;
              end
            end
          endcase
        end
      end
      default: ;
    endcase
    if (more) begin
      ovalid_d = 1'b1;
    end
  end

  // Search and dump hold their last hit until the walk ends, so last can be set.
  // Implemented by a one-beat delay register for streamed results.
  logic              hold_v_q, hold_v_d;
  bdq_pkg::out_beat_t hold_q, hold_d;
  logic              stream;
  logic              push, pop_fin;

  assign stream = (cmd_q.cmd == bdq_pkg::CMD_SEARCH) || (cmd_q.cmd == bdq_pkg::CMD_DUMP);
  assign push   = (state_q == bdq_pkg::FSM_EMIT) && out_free && cmd_d.item_value[0];
  assign pop_fin = (state_q == bdq_pkg::FSM_FINAL) && out_free && (nres_q != '0);

  bdq_pkg::out_beat_t oreg_d;
  logic               oreg_v_d;

  always_comb begin
    hold_v_d = hold_v_q;
    hold_d   = hold_q;
    oreg_d   = obeat_d;
    oreg_v_d = ovalid_d;
    if (stream && (state_q == bdq_pkg::FSM_EMIT || state_q == bdq_pkg::FSM_FINAL)) begin
      oreg_d   = obeat_q;
      oreg_v_d = ovalid_q && out_stall_i;
      if (push) begin
        hold_d   = obeat_d;
        hold_v_d = 1'b1;
        if (hold_v_q) begin
          oreg_d   = hold_q;
          oreg_v_d = 1'b1;
        end
      end else if (pop_fin) begin
        oreg_d      = hold_q;
        oreg_d.last = 1'b1;
        oreg_v_d    = 1'b1;
        hold_v_d    = 1'b0;
      end else if (state_q == bdq_pkg::FSM_FINAL) begin
        oreg_d   = obeat_d;
        oreg_v_d = ovalid_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bdq_pkg::FSM_IDLE;
      front_q  <= '0;
      count_q  <= '0;
      ovalid_q <= 1'b0;
      hold_v_q <= 1'b0;
      idx_q    <= '0;
      nres_q   <= '0;
    end else begin
      state_q  <= state_d;
      front_q  <= front_d;
      count_q  <= count_d;
      ovalid_q <= oreg_v_d;
      hold_v_q <= hold_v_d;
      idx_q    <= idx_d;
      nres_q   <= nres_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    prod_q  <= prod_d;
    elem_q  <= elem_d;
    obeat_q <= oreg_d;
    hold_q  <= hold_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_beat_o  = obeat_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(bdq_pkg::ListDepth)) else $error("count overflow");
  a_idle_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bdq_pkg::FSM_IDLE |-> !hold_v_q) else $error("hit left pending");
  a_count_stable_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != bdq_pkg::FSM_FINAL && state_q != bdq_pkg::FSM_IDLE) |=> $stable(count_q))
    else $error("count moved mid command");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("stalled beat changed");
`endif

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int unsigned Depth = bdq_pkg::ListDepth;
  localparam int unsigned ResLimit = bdq_pkg::ResultLimit;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned MaxShown = 10;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  bdq_pkg::in_beat_t  in_beat_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  bdq_pkg::out_beat_t out_beat_o;

  bounded_deque_search_engine dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_beat_i(in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o(out_beat_o)
  );

  always #4 clk_i = ~clk_i;

  // shadow copy of the deque
  logic [31:0]        shadow_ring [Depth];
  int unsigned        shadow_head;
  int unsigned        shadow_count;
  bdq_pkg::out_beat_t pending_results[$];
  int unsigned        mismatches;
  int unsigned        cycle_count;
  bit                 sender_gaps;
  bit                 receiver_gaps;
  int unsigned        hold_cycles;

  function automatic int unsigned ring_slot(int unsigned idx);
    return (shadow_head + idx) % Depth;
  endfunction

  function automatic logic [31:0] abs_word(logic [31:0] v);
    return v[31] ? 32'd0 - v : v;
  endfunction

  function automatic bdq_pkg::out_beat_t make_beat(bdq_pkg::status_e st, int unsigned pos,
                                                   logic [31:0] val, logic lst);
    bdq_pkg::out_beat_t b;
    b.status = st;
    b.position = pos[3:0];
    b.result_value = val;
    b.last = lst;
    return b;
  endfunction

  task automatic predict_deque(bdq_pkg::in_beat_t b);
    logic [31:0] prod;
    logic [31:0] md;
    logic [31:0] e;
    int n;
    n = 0;
    case (b.cmd)
      bdq_pkg::CMD_APPEND: begin
        if (shadow_count >= Depth) begin
          pending_results.push_back(make_beat(bdq_pkg::ST_FULL, 0, 0, 1'b1));
        end else begin
          shadow_ring[ring_slot(shadow_count)] = b.item_value;
          pending_results.push_back(make_beat(bdq_pkg::ST_OK, shadow_count, b.item_value,
                                              1'b1));
          shadow_count++;
        end
      end
      bdq_pkg::CMD_POP_HEAD: begin
        if (shadow_count == 0) begin
          pending_results.push_back(make_beat(bdq_pkg::ST_EMPTY, 0, 0, 1'b1));
        end else begin
          pending_results.push_back(make_beat(bdq_pkg::ST_OK, 0, shadow_ring[shadow_head],
                                              1'b1));
          shadow_head = ring_slot(1);
          shadow_count--;
        end
      end
      bdq_pkg::CMD_POP_TAIL: begin
        if (shadow_count == 0) begin
          pending_results.push_back(make_beat(bdq_pkg::ST_EMPTY, 0, 0, 1'b1));
        end else begin
          shadow_count--;
          pending_results.push_back(make_beat(bdq_pkg::ST_OK, shadow_count,
                                              shadow_ring[ring_slot(shadow_count)], 1'b1));
        end
      end
      bdq_pkg::CMD_SEARCH: begin
        for (int i = 0; i < shadow_count && n < ResLimit; i++) begin
          if (shadow_ring[ring_slot(i)] == b.search_key) begin
            pending_results.push_back(make_beat(bdq_pkg::ST_OK, i, b.search_key, 1'b0));
            n++;
          end
        end
        if (n == 0) pending_results.push_back(make_beat(bdq_pkg::ST_NOTFOUND, 0, 0, 1'b1));
        else pending_results[$].last = 1'b1;
      end
      bdq_pkg::CMD_PRODUCT: begin
        if (b.divisor == 0) begin
          pending_results.push_back(make_beat(bdq_pkg::ST_ZERO_DIV, 0, 0, 1'b1));
        end else begin
          prod = 32'd1;
          md = abs_word(b.divisor);
          for (int i = 0; i < shadow_count; i++) begin
            e = shadow_ring[ring_slot(i)];
            if (abs_word(e) % md == 0) prod = prod * e;
          end
          pending_results.push_back(make_beat(bdq_pkg::ST_OK, 0, prod, 1'b1));
        end
      end
      bdq_pkg::CMD_DUMP: begin
        if (shadow_count == 0) begin
          pending_results.push_back(make_beat(bdq_pkg::ST_EMPTY, 0, 0, 1'b1));
        end else begin
          for (int i = 0; i < shadow_count && i < ResLimit; i++)
            pending_results.push_back(make_beat(bdq_pkg::ST_OK, i,
                                                shadow_ring[ring_slot(i)], 1'b0));
          pending_results[$].last = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // one beat on the input channel; valid stays high across back-to-back beats
  task automatic send_beat(logic [2:0] cmd, logic [31:0] item, logic [31:0] key,
                           logic [31:0] dv);
    bdq_pkg::in_beat_t b;
    b.cmd = cmd;
    b.item_value = item;
    b.search_key = key;
    b.divisor = dv;
    while (sender_gaps && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_deque(b);
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(8) - 4;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= receiver_gaps && ($urandom_range(99) < 17);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    bdq_pkg::out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown) $display("unexpected beat %p", out_beat_o);
      end else begin
        want = pending_results.pop_front();
        if (out_beat_o !== want) begin
          mismatches++;
          if (mismatches <= MaxShown) $display("expected %p got %p", want, out_beat_o);
        end
      end
    end
  end

  task automatic test_edges();
    // empty list cases, unused command codes, then extreme words appended and queried
    send_beat(bdq_pkg::CMD_POP_HEAD, 0, 0, 0);
    send_beat(bdq_pkg::CMD_POP_TAIL, 0, 0, 0);
    send_beat(bdq_pkg::CMD_SEARCH, 0, 0, 0);
    send_beat(bdq_pkg::CMD_DUMP, 0, 0, 0);
    send_beat(bdq_pkg::CMD_PRODUCT, 0, 0, 5);
    send_beat(bdq_pkg::CMD_PRODUCT, 0, 0, 0);
    send_beat(3'd6, $urandom, $urandom, $urandom);
    send_beat(3'd7, $urandom, $urandom, $urandom);
    send_beat(bdq_pkg::CMD_APPEND, 32'h8000_0000, 0, 0);
    send_beat(bdq_pkg::CMD_APPEND, 32'h7fff_ffff, 0, 0);
    send_beat(bdq_pkg::CMD_APPEND, 32'hffff_ffff, 0, 0);
    send_beat(bdq_pkg::CMD_APPEND, 32'h8000_0000, 0, 0);
    send_beat(bdq_pkg::CMD_PRODUCT, 0, 0, 32'hffff_ffff);
    send_beat(bdq_pkg::CMD_PRODUCT, 0, 0, 32'h8000_0000);
    send_beat(bdq_pkg::CMD_SEARCH, 0, 32'h8000_0000, 0);
    send_beat(bdq_pkg::CMD_DUMP, 0, 0, 0);
    // fill until full, then one more, then search with all but two entries matching
    for (int i = 0; i < 13; i++) send_beat(bdq_pkg::CMD_APPEND, 32'h8000_0000, 0, 0);
    send_beat(bdq_pkg::CMD_SEARCH, 0, 32'h8000_0000, 0);
    send_beat(bdq_pkg::CMD_DUMP, 0, 0, 0);
    send_beat(bdq_pkg::CMD_POP_TAIL, 0, 0, 0);
    send_beat(bdq_pkg::CMD_POP_HEAD, 0, 0, 0);
    go_idle();
  endtask

  task automatic test_backpressure();
    // receiver holds off while the sender keeps offering
    hold_cycles = 400;
    for (int i = 0; i < 6; i++) send_beat(bdq_pkg::CMD_DUMP, 0, 0, 0);
    go_idle();
  endtask

  task automatic test_random(int unsigned count);
    logic [2:0] c;
    for (int unsigned k = 0; k < count; k++) begin
      sender_gaps = (k % 120) > 40;
      receiver_gaps = (k % 120) > 40;
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5: c = bdq_pkg::CMD_APPEND;
        6, 7: c = bdq_pkg::CMD_POP_HEAD;
        8, 9: c = bdq_pkg::CMD_POP_TAIL;
        10, 11, 12: c = bdq_pkg::CMD_SEARCH;
        13, 14: c = bdq_pkg::CMD_PRODUCT;
        15, 16, 17: c = bdq_pkg::CMD_DUMP;
        default: c = 3'($urandom_range(7));
      endcase
      // product is slow on a long list, keep most of them small
      if (c == bdq_pkg::CMD_PRODUCT && shadow_count > 6 && $urandom_range(3) != 0)
        c = bdq_pkg::CMD_POP_HEAD;
      if (c == bdq_pkg::CMD_SEARCH && shadow_count != 0 && $urandom_range(1))
        send_beat(c, rand_word(), shadow_ring[ring_slot($urandom_range(shadow_count - 1))],
                  rand_word());
      else
        send_beat(c, rand_word(), rand_word(), rand_word());
    end
    go_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edges();
    test_backpressure();
    test_random(290);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### bounded_deque_search_engine.f
src/bdq_pkg.sv
src/bdq_divider.sv
src/bounded_deque_search_engine.sv
test/tb.sv
